/* sv/pfbe_pkg.sv */
`default_nettype none
package pfbe_pkg;
   localparam int DisplayWidthDefault  = 128;
   localparam int DisplayHeightDefault = 64;

   typedef enum logic [2:0] {
      REQ_FILL   = 3'd0,
      REQ_HSHIFT = 3'd1,
      REQ_VSHIFT = 3'd2,
      REQ_RUN    = 3'd3,
      REQ_READ   = 3'd4
   } req_code_type;

   localparam logic [7:0] BYTE_ONES = 8'hff;
   localparam logic [7:0] BIT_TOP   = 8'h80;
endpackage
`default_nettype wire

/* sv/pfbe_ram.sv */
`default_nettype none
module pfbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/page_framebuffer_blit_engine_top.sv */
`default_nettype none
// Monochrome page frame engine. Commands are taken one at a time; req_stall
// is high from acceptance until the result beat is taken. The engine works
// pixel by pixel through one shared read-modify-write unit on the frame RAM:
// each fill or scroll pixel passes through read, wait, write and step states.
// A scroll first copies each line into a line buffer and then writes it
// back, so it passes over each line twice. A run write checks each run
// pixel in a setup state and reads, waits and writes only those that land
// on screen; a read of an on-screen pixel goes through read, wait and write.
// Each command passes through the result state and back to idle before the
// next accept. After reset all W*ceil(H/8) bytes of the RAM are cleared, one
// byte a cycle, before the first command is taken.
module page_framebuffer_blit_engine_top #(
   parameter int DISPLAY_WIDTH  = pfbe_pkg::DisplayWidthDefault,
   parameter int DISPLAY_HEIGHT = pfbe_pkg::DisplayHeightDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_type,
   input  wire logic signed [8:0] req_pos_x,
   input  wire logic signed [8:0] req_pos_y,
   input  wire logic [7:0]        req_area_w,
   input  wire logic [7:0]        req_area_h,
   input  wire logic signed [7:0] req_shift_amount,
   input  wire logic              req_fill_value,
   input  wire logic [15:0]       req_source_bits,
   input  wire logic [2:0]        req_source_bit_offset,
   input  wire logic [3:0]        req_run_length,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_read_byte,
   output logic                   rsp_status
);
   localparam int Pages     = (DISPLAY_HEIGHT + 7) / 8;
   localparam int Depth     = DISPLAY_WIDTH * Pages;
   localparam int AW        = $clog2(Depth);
   localparam int CW        = $clog2(DISPLAY_WIDTH);
   localparam int PW        = (Pages > 1) ? $clog2(Pages) : 1;
   localparam int LineDepth = 256;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SETUP, S_RD, S_WAIT, S_WR, S_NEXT, S_RESP
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_ff;
   // bounds (clipped for fill and scroll) and position, 10-bit signed
   logic signed [9:0] x0_ff, x1_ff, y0_ff, y1_ff, x_ff, y_ff;
   logic signed [9:0] sh_ff;
   logic [2:0]  op_ff;
   logic        fv_ff, phase_ff;      // phase 0 = copy line into buffer, 1 = write
   logic [15:0] src_ff;
   logic [3:0]  i_ff, rl_ff;
   logic [2:0]  soff_ff;
   logic [7:0]  rb_ff;
   logic        st_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   logic          tmp_wr_en, tmp_wr_data, tmp_rd_data;
   logic [7:0]    tmp_wr_addr, tmp_rd_addr;

   pfbe_ram #(.WIDTH(8), .DEPTH(Depth)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // current pixel address
   logic signed [9:0] px, py, s_pos, lo, hi;
   logic [AW-1:0] pix_addr;
   logic [7:0] bitmask;
   logic pix_val, cur_bit;
   logic is_h;
   always_comb begin
      is_h = (op_ff == pfbe_pkg::REQ_HSHIFT);
      px = (op_ff == pfbe_pkg::REQ_RUN) ? x0_ff + 10'(i_ff) : x_ff;
      py = y_ff;
      pix_addr = AW'(({1'b0, py[9:3]} & ((1 << PW) - 1)) * DISPLAY_WIDTH)
                 + AW'(px[CW-1:0]);
      if (DISPLAY_WIDTH == (1 << CW)) pix_addr = AW'(px) + AW'(py[9:3] * DISPLAY_WIDTH);
      else pix_addr = AW'(py[9:3] * DISPLAY_WIDTH) + AW'(px);
      bitmask = 8'(1) << py[2:0];
      cur_bit = rd_data[py[2:0]];
      s_pos = (is_h ? x_ff : y_ff) - sh_ff;
      lo = is_h ? x0_ff : y0_ff;
      hi = is_h ? x1_ff : y1_ff;
      unique case (op_ff)
         pfbe_pkg::REQ_FILL: pix_val = fv_ff;
         pfbe_pkg::REQ_RUN:  pix_val = src_ff[4'd15 - (4'(soff_ff) + i_ff)];
         default:            pix_val = (s_pos >= lo && s_pos < hi) ?
                                       tmp_rd_data : fv_ff;
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pix_addr;
      wr_data = pix_val ? (rd_data | bitmask) : (rd_data & (bitmask ^ pfbe_pkg::BYTE_ONES));
      rd_addr = pix_addr;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1; wr_addr = clr_ff; wr_data = '0;
      end else if (state_ff == S_WR && !(phase_ff == 1'b0 && op_ff != pfbe_pkg::REQ_FILL
                   && op_ff != pfbe_pkg::REQ_RUN && op_ff != pfbe_pkg::REQ_READ)) begin
         wr_en = (op_ff != pfbe_pkg::REQ_READ);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_read_byte = rb_ff;
   assign rsp_status = st_ff;

   // clip helpers on incoming beat
   logic signed [9:0] ax, bx, ay, by;
   always_comb begin
      ax = (req_pos_x < 0) ? 10'sd0 : 10'(req_pos_x);
      bx = 10'(req_pos_x) + 10'(req_area_w);
      if (bx > DISPLAY_WIDTH) bx = 10'(DISPLAY_WIDTH);
      ay = (req_pos_y < 0) ? 10'sd0 : 10'(req_pos_y);
      by = 10'(req_pos_y) + 10'(req_area_h);
      if (by > DISPLAY_HEIGHT) by = 10'(DISPLAY_HEIGHT);
   end

   logic last_inner;
   logic signed [9:0] inner_pos, inner_hi;
   always_comb begin
      // vertical shift walks columns outer, rows inner
      inner_pos = (op_ff == pfbe_pkg::REQ_VSHIFT) ? y_ff : x_ff;
      inner_hi  = (op_ff == pfbe_pkg::REQ_VSHIFT) ? y1_ff : x1_ff;
      last_inner = (inner_pos + 10'sd1 >= inner_hi);
   end

   // line buffer: copy pass stores each pixel, write pass reads its source
   assign tmp_wr_en   = (state_ff == S_WR) && !phase_ff &&
                        (op_ff == pfbe_pkg::REQ_HSHIFT || op_ff == pfbe_pkg::REQ_VSHIFT);
   assign tmp_wr_addr = inner_pos[7:0];
   assign tmp_wr_data = cur_bit;
   assign tmp_rd_addr = s_pos[7:0];

   pfbe_ram #(.WIDTH(1), .DEPTH(LineDepth)) u_line_ram (
      .clock,
      .wr_en(tmp_wr_en), .wr_addr(tmp_wr_addr), .wr_data(tmp_wr_data),
      .rd_addr(tmp_rd_addr), .rd_data(tmp_rd_data)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         st_ff <= 1'b1;
         rb_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(Depth - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid) begin
               op_ff <= req_type; fv_ff <= req_fill_value;
               sh_ff <= 10'(req_shift_amount);
               src_ff <= req_source_bits; soff_ff <= req_source_bit_offset;
               rl_ff <= (req_run_length > 4'd8) ? 4'd8 : req_run_length;
               i_ff <= '0; phase_ff <= 1'b0;
               rb_ff <= '0; st_ff <= 1'b1;
               x0_ff <= ax; x1_ff <= bx; y0_ff <= ay; y1_ff <= by;
               x_ff <= ax; y_ff <= ay;
               state_ff <= S_RESP;
               priority if (req_type <= pfbe_pkg::REQ_VSHIFT) begin
                  if (bx > ax && by > ay) begin
                     st_ff <= 1'b0;
                     if (req_type == pfbe_pkg::REQ_FILL || req_shift_amount != 0)
                        state_ff <= S_RD;
                  end
               end else if (req_type == pfbe_pkg::REQ_RUN) begin
                  x0_ff <= 10'(req_pos_x); y_ff <= 10'(req_pos_y);
                  state_ff <= S_SETUP;
               end else if (req_type == pfbe_pkg::REQ_READ) begin
                  x_ff <= 10'(req_pos_x); y_ff <= 10'(req_pos_y);
                  if (req_pos_x >= 0 && req_pos_x < DISPLAY_WIDTH &&
                      req_pos_y >= 0 && req_pos_y < DISPLAY_HEIGHT) state_ff <= S_RD;
               end
            end
            S_SETUP: begin
               // run pixel: skip if off screen
               if (i_ff >= rl_ff) state_ff <= S_RESP;
               else if (px >= 0 && px < DISPLAY_WIDTH && py >= 0 && py < DISPLAY_HEIGHT)
                  state_ff <= S_RD;
               else i_ff <= i_ff + 4'd1;
            end
            S_RD:   state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_WR;
            S_WR: begin
               if (op_ff == pfbe_pkg::REQ_READ) begin
                  rb_ff <= rd_data; st_ff <= 1'b0; state_ff <= S_RESP;
               end else if (op_ff == pfbe_pkg::REQ_RUN) begin
                  st_ff <= 1'b0; i_ff <= i_ff + 4'd1; state_ff <= S_SETUP;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               state_ff <= S_RD;
               if (!last_inner) begin
                  if (op_ff == pfbe_pkg::REQ_VSHIFT) y_ff <= y_ff + 10'sd1;
                  else x_ff <= x_ff + 10'sd1;
               end else if (op_ff != pfbe_pkg::REQ_FILL && !phase_ff) begin
                  phase_ff <= 1'b1;
                  if (op_ff == pfbe_pkg::REQ_VSHIFT) y_ff <= y0_ff; else x_ff <= x0_ff;
               end else begin
                  phase_ff <= 1'b0;
                  if (op_ff == pfbe_pkg::REQ_VSHIFT) begin
                     y_ff <= y0_ff;
                     if (x_ff + 10'sd1 >= x1_ff) state_ff <= S_RESP;
                     else x_ff <= x_ff + 10'sd1;
                  end else begin
                     x_ff <= x0_ff;
                     if (y_ff + 10'sd1 >= y1_ff) state_ff <= S_RESP;
                     else y_ff <= y_ff + 10'sd1;
                  end
               end
            end
            S_RESP: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // a result beat never shows during the clearing sweep
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid) else $error("result during clear");
   // no input accepted while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_read_byte) && $stable(rsp_status))
      else $error("result changed under stall");
endmodule
`default_nettype wire
